// File: design/assert_macros.svh
// assertion macros for the deadline timer queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define DTQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define DTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/dtq_pkg.sv
// shared types and constants for the deadline timer queue
`timescale 1ns / 1ps
package dtq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int ID_BITS_DEF   = 8;

  localparam int TASK_W  = 8;
  localparam int DELAY_W = 16;
  localparam int STAT_W  = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPT  = 2'd0,
    ST_FULL    = 2'd1,
    ST_RELEASE = 2'd2,
    ST_IDLE    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_ADD_OK,
    S_ADD_FULL,
    S_T_RD0,
    S_T_ROOT,
    S_T_LAST,
    S_DN_RD,
    S_DN_CMP
  } state_t;

endpackage

// File: design/dtq_heap_mem.sv
// heap entry memory: one write port, two registered read ports
`timescale 1ns / 1ps
module dtq_heap_mem #(
  parameter int DEPTH = dtq_pkg::CAPACITY_DEF,
  parameter int WIDTH = dtq_pkg::TIME_BITS_DEF + dtq_pkg::ID_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/deadline_timer_queue.sv
// deadline timer queue top level: heap sequencer, tick counter, output register
//
// channel  | dir | tdata                          | tuser      | tlast
// s_axis   | in  | task_id[7:0], delay_ticks[23:8] | kind[0]    | -
// m_axis   | out | released_task[7:0]             | status[1:0]| last
//
// add: the new entry climbs the heap, reading (S_UP_RD) and comparing (S_UP_CMP) per level, then S_ADD_OK
// tick: reads the root, releases each due task and sifts the last entry down (none when the heap empties)
// heap walk is bound by the single memory write port and its registered read
// synchronous active-high reset clears time, count and control; memory is not cleared
// the next item is taken once the previous one has handed its last result to the output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module deadline_timer_queue #(
  parameter int CAPACITY  = dtq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF,
  parameter int ID_BITS   = dtq_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // task_id[7:0], delay_ticks[23:8]
  input  logic [0:0]  s_axis_tuser,   // kind[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // released_task[7:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int ENT = TIME_BITS + ID_BITS;

  function automatic logic earlier(input logic [ENT-1:0] a, input logic [ENT-1:0] b);
    logic dl_lt;
    logic dl_eq;
    dl_lt = a[ENT-1:ID_BITS] < b[ENT-1:ID_BITS];
    dl_eq = a[ENT-1:ID_BITS] == b[ENT-1:ID_BITS];
    earlier = dl_lt || (dl_eq && (a[ID_BITS-1:0] < b[ID_BITS-1:0]));
  endfunction

  dtq_pkg::state_t state, state_next;

  logic [TIME_BITS-1:0] cur_time, cur_time_next;
  logic [CW-1:0]        count, count_next;
  logic [ENT-1:0]       cur, cur_next;
  logic [AW-1:0]        hole, hole_next;
  logic                 pend_valid, pend_valid_next;
  logic [ID_BITS-1:0]   pend_task, pend_task_next;

  logic                 out_valid;
  logic [1:0]           out_status;
  logic [7:0]           out_task;
  logic                 out_last;

  logic                 emit;
  dtq_pkg::status_t     emit_status;
  logic [ID_BITS-1:0]   emit_task;
  logic                 emit_last;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ENT-1:0]       mem_wdata;
  logic [AW-1:0]        raddr_a;
  logic [AW-1:0]        raddr_b;
  logic [ENT-1:0]       rd_a;
  logic [ENT-1:0]       rd_b;

  logic                 in_xfer;
  logic                 in_kind;
  logic [TIME_BITS:0]   dl_sum;
  logic [TIME_BITS-1:0] dl_sat;
  logic                 can_emit;
  logic                 due;
  logic                 full;
  logic [AW-1:0]        parent;
  logic [AW+1:0]        l_idx;
  logic [AW+1:0]        r_idx;
  logic                 l_ok;
  logic                 r_ok;
  logic [ENT-1:0]       best;
  logic                 move_child;
  logic [AW-1:0]        best_idx;

  dtq_heap_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign s_axis_tready = (state == dtq_pkg::S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_kind       = s_axis_tuser[0];

  assign dl_sum = {1'b0, cur_time} + (TIME_BITS + 1)'(s_axis_tdata[23:8]);
  assign dl_sat = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

  assign can_emit = !out_valid || m_axis_tready;
  assign full     = (count == CW'(CAPACITY));
  assign due      = (count != '0) && (rd_a[ENT-1:ID_BITS] <= cur_time);
  assign parent   = (hole - AW'(1)) >> 1;
  assign l_idx    = {1'b0, hole, 1'b1};
  assign r_idx    = l_idx + (AW + 2)'(1);
  assign l_ok     = l_idx < (AW + 2)'(count);
  assign r_ok     = r_idx < (AW + 2)'(count);

  always_comb begin
    best       = cur;
    best_idx   = hole;
    move_child = 1'b0;
    if (l_ok && earlier(rd_a, best)) begin
      best       = rd_a;
      best_idx   = AW'(l_idx);
      move_child = 1'b1;
    end
    if (r_ok && earlier(rd_b, best)) begin
      best       = rd_b;
      best_idx   = AW'(r_idx);
      move_child = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dtq_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_kind) begin
            state_next = dtq_pkg::S_T_RD0;
          end else if (full) begin
            state_next = dtq_pkg::S_ADD_FULL;
          end else begin
            state_next = dtq_pkg::S_UP_RD;
          end
        end
      end
      dtq_pkg::S_UP_RD: begin
        state_next = (hole == '0) ? dtq_pkg::S_ADD_OK : dtq_pkg::S_UP_CMP;
      end
      dtq_pkg::S_UP_CMP: begin
        state_next = earlier(cur, rd_a) ? dtq_pkg::S_UP_RD : dtq_pkg::S_ADD_OK;
      end
      dtq_pkg::S_ADD_OK, dtq_pkg::S_ADD_FULL: begin
        if (can_emit) begin
          state_next = dtq_pkg::S_IDLE;
        end
      end
      dtq_pkg::S_T_RD0: begin
        state_next = dtq_pkg::S_T_ROOT;
      end
      dtq_pkg::S_T_ROOT: begin
        if (due) begin
          if (!pend_valid || can_emit) begin
            state_next = (count == CW'(1)) ? dtq_pkg::S_T_RD0 : dtq_pkg::S_T_LAST;
          end
        end else if (can_emit) begin
          state_next = dtq_pkg::S_IDLE;
        end
      end
      dtq_pkg::S_T_LAST: begin
        state_next = dtq_pkg::S_DN_RD;
      end
      dtq_pkg::S_DN_RD: begin
        state_next = dtq_pkg::S_DN_CMP;
      end
      dtq_pkg::S_DN_CMP: begin
        state_next = move_child ? dtq_pkg::S_DN_RD : dtq_pkg::S_T_RD0;
      end
      default: begin
        state_next = dtq_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    cur_time_next   = cur_time;
    count_next      = count;
    cur_next        = cur;
    hole_next       = hole;
    pend_valid_next = pend_valid;
    pend_task_next  = pend_task;
    mem_we          = 1'b0;
    mem_waddr       = hole;
    mem_wdata       = cur;
    raddr_a         = '0;
    raddr_b         = '0;
    emit            = 1'b0;
    emit_status     = dtq_pkg::ST_ACCEPT;
    emit_task       = '0;
    emit_last       = 1'b1;
    case (state)
      dtq_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_kind) begin
            if (cur_time != '1) begin
              cur_time_next = cur_time + TIME_BITS'(1);
            end
            pend_valid_next = 1'b0;
          end else if (!full) begin
            cur_next   = {dl_sat, ID_BITS'(s_axis_tdata[7:0])};
            hole_next  = AW'(count);
            count_next = count + CW'(1);
          end
        end
      end
      dtq_pkg::S_UP_RD: begin
        if (hole == '0) begin
          mem_we = 1'b1;
        end else begin
          raddr_a = parent;
        end
      end
      dtq_pkg::S_UP_CMP: begin
        mem_we = 1'b1;
        if (earlier(cur, rd_a)) begin
          mem_wdata = rd_a;
          hole_next = parent;
        end
      end
      dtq_pkg::S_ADD_OK: begin
        emit = can_emit;
      end
      dtq_pkg::S_ADD_FULL: begin
        emit        = can_emit;
        emit_status = dtq_pkg::ST_FULL;
      end
      dtq_pkg::S_T_ROOT: begin
        if (due) begin
          if (!pend_valid || can_emit) begin
            emit            = pend_valid;
            emit_status     = dtq_pkg::ST_RELEASE;
            emit_task       = pend_task;
            emit_last       = 1'b0;
            pend_valid_next = 1'b1;
            pend_task_next  = rd_a[ID_BITS-1:0];
            count_next      = count - CW'(1);
            raddr_a         = AW'(count - CW'(1));
          end
        end else begin
          emit        = can_emit;
          emit_status = pend_valid ? dtq_pkg::ST_RELEASE : dtq_pkg::ST_IDLE;
          emit_task   = pend_valid ? pend_task : '0;
        end
      end
      dtq_pkg::S_T_LAST: begin
        cur_next  = rd_a;
        hole_next = '0;
      end
      dtq_pkg::S_DN_RD: begin
        raddr_a = AW'(l_idx);
        raddr_b = AW'(r_idx);
      end
      dtq_pkg::S_DN_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = best;
        hole_next = best_idx;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dtq_pkg::S_IDLE;
      cur_time   <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur_time   <= cur_time_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    hole      <= hole_next;
    pend_task <= pend_task_next;
    if (emit) begin
      out_status <= emit_status;
      out_task   <= 8'(emit_task);
      out_last   <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_task;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

  `DTQ_ASSERT(a_count_range, count <= CW'(CAPACITY), "entry count beyond capacity")
  `DTQ_ASSERT(a_emit_free, !emit || !out_valid || m_axis_tready, "result overwrites a waiting one")
  `DTQ_ASSERT_NEXT(a_busy_after_take, in_xfer, !s_axis_tready, "item taken without leaving idle")
  `DTQ_ASSERT_NEXT(a_up_write, state == dtq_pkg::S_UP_CMP, count == $past(count), "count moved during sift-up")

endmodule
